// ----- src/rtrm_pkg.sv -----
// Shared types, constants and controller/datapath interface for the runaway task rate monitor.
package rtrm_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 64;

  localparam int unsigned ID_W      = 22;
  localparam int unsigned TICK_W    = 32;
  localparam int unsigned STRIKE_W  = 8;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 4;

  localparam logic [CFG_W-1:0]    INTERVAL_RST   = 16'd2;
  localparam logic [CFG_W-1:0]    TRIGGER_RST    = 16'd20;
  localparam logic [5:0]          STRIKE_TPS     = 6'd40;
  localparam logic [STRIKE_W-1:0] STRIKE_MAX     = 8'hFF;
  localparam int unsigned         STRIKE_THR_W   = CFG_W + 6;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER  = 4'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_HIT,
    ST_MISS,
    ST_EMIT
  } rtrm_state_t;

  typedef struct packed {
    logic latch;     // capture the accepted transaction, rewind the scan
    logic do_sys;    // system sample: difference, threshold, scan enable
    logic do_quiet;  // task sample while scanning is off
    logic scan_step; // advance the table search by one entry
    logic do_hit;    // update the matching entry
    logic do_miss;   // insert a new id or flag a full table
    logic emit;      // load the output register
  } rtrm_cmd_t;

  typedef struct packed {
    logic item_task; // latched transaction is a task sample
    logic scan_en;   // task scanning is enabled
    logic hit;       // search found the id
    logic miss;      // search ran past the last filled entry
    logic out_free;  // output register can take a result
  } rtrm_sts_t;

  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [TICK_W-1:0]   ticks;
    logic [STRIKE_W-1:0] strikes;
  } tbl_entry_t;

endpackage

// ----- src/rtrm_ctrl.sv -----
// Controller state machine of the runaway task rate monitor.
module rtrm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rtrm_pkg::rtrm_sts_t sts,
  output rtrm_pkg::rtrm_cmd_t cmd
);
  import rtrm_pkg::*;

  rtrm_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        if (sts.item_task && sts.scan_en) state_nxt = ST_SCAN;
        else                              state_nxt = ST_EMIT;
      end
      ST_SCAN: begin
        if (sts.hit)       state_nxt = ST_HIT;
        else if (sts.miss) state_nxt = ST_MISS;
      end
      ST_HIT:  state_nxt = ST_EMIT;
      ST_MISS: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall  = 1'b0;
        cmd.latch = in_valid;
      end
      ST_DECODE: begin
        cmd.do_sys   = !sts.item_task;
        cmd.do_quiet = sts.item_task && !sts.scan_en;
      end
      ST_SCAN: cmd.scan_step = 1'b1;
      ST_HIT:  cmd.do_hit    = 1'b1;
      ST_MISS: cmd.do_miss   = 1'b1;
      ST_EMIT: cmd.emit      = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ----- src/rtrm_dp.sv -----
// Datapath of the runaway task rate monitor: config, system state, task table, result registers.
module rtrm_dp #(
  parameter int unsigned TABLE_ENTRIES = rtrm_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  input  logic [rtrm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rtrm_pkg::CFG_W-1:0]         cfg_data,
  input  logic                               in_command,
  input  logic [rtrm_pkg::ID_W-1:0]          in_task_id,
  input  logic [rtrm_pkg::TICK_W-1:0]        in_tick_counter,
  input  logic                               in_may_kill,
  input  rtrm_pkg::rtrm_cmd_t                cmd,
  output rtrm_pkg::rtrm_sts_t                sts,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [rtrm_pkg::TICK_W-1:0]        out_system_delta,
  output logic                               out_scan_armed,
  output logic [rtrm_pkg::ID_W-1:0]          out_reported_id,
  output logic                               out_runaway,
  output logic [rtrm_pkg::STRIKE_W-1:0]      out_strike_count,
  output logic                               out_table_full
);
  import rtrm_pkg::*;

  localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_ENTRIES);

  // Configuration and derived thresholds
  logic [CFG_W-1:0]        interval_r, trigger_r;
  logic [TICK_W-1:0]       sys_thr_r;
  logic [STRIKE_THR_W-1:0] strike_thr_r;

  // System state
  logic [TICK_W-1:0] last_sys_r;
  logic              scan_en_r;
  logic [CW-1:0]     fill_r;

  // Latched transaction
  logic              item_task_r;
  logic [ID_W-1:0]   item_id_r;
  logic [TICK_W-1:0] item_ticks_r;
  logic              item_kill_r;

  // Search
  logic [CW-1:0] scan_idx_r;
  logic          pend_r;
  logic [AW-1:0] pend_idx_r;

  // Table memory
  tbl_entry_t    mem [TABLE_ENTRIES];
  tbl_entry_t    rdata_r;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  tbl_entry_t    wr_data;

  // Pending result
  logic [TICK_W-1:0]   res_delta_r;
  logic                res_armed_r;
  logic [ID_W-1:0]     res_id_r;
  logic                res_runaway_r;
  logic [STRIKE_W-1:0] res_strikes_r;
  logic                res_full_r;

  logic                out_valid_r;

  logic [TICK_W-1:0]   sys_diff, sys_delta;
  logic                sys_armed;
  logic [TICK_W-1:0]   task_diff;
  logic                bad;
  logic [STRIKE_W-1:0] strikes_nxt;
  logic                runaway_nxt;
  logic                hit, miss, out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= INTERVAL_RST;
      trigger_r  <= TRIGGER_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_INTERVAL: interval_r <= cfg_data;
        CFG_TRIGGER:  trigger_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    sys_thr_r    <= trigger_r * interval_r;
    strike_thr_r <= interval_r * STRIKE_TPS;
  end

  assign sys_diff  = item_ticks_r - last_sys_r;
  assign sys_delta = (last_sys_r == '0) ? '0 : sys_diff;
  assign sys_armed = sys_delta > sys_thr_r;

  assign task_diff = item_ticks_r - rdata_r.ticks;
  assign bad       = task_diff > TICK_W'(strike_thr_r);

  always_comb begin
    strikes_nxt = '0;
    runaway_nxt = 1'b0;
    if (bad) begin
      if (rdata_r.strikes != '0) begin
        strikes_nxt = (rdata_r.strikes == STRIKE_MAX) ? STRIKE_MAX
                                                     : rdata_r.strikes + 1'b1;
        runaway_nxt = item_kill_r;
      end else begin
        strikes_nxt = STRIKE_W'(1);
      end
    end
  end

  assign hit      = pend_r && (rdata_r.id == item_id_r);
  assign miss     = !pend_r && (scan_idx_r == fill_r);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    rd_en   = cmd.scan_step && !hit && !miss && (scan_idx_r != fill_r);
    rd_addr = scan_idx_r[AW-1:0];
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pend_idx_r;
    wr_data = '{id: item_id_r, ticks: item_ticks_r, strikes: strikes_nxt};
    if (cmd.do_hit) begin
      wr_en = 1'b1;
    end else if (cmd.do_miss && (fill_r != FULL_CNT)) begin
      wr_en   = 1'b1;
      wr_addr = fill_r[AW-1:0];
      wr_data = '{id: item_id_r, ticks: item_ticks_r, strikes: '0};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_task_r  <= in_command;
      item_id_r    <= in_task_id;
      item_ticks_r <= in_tick_counter;
      item_kill_r  <= in_may_kill;
    end
    if (rd_en) pend_idx_r <= scan_idx_r[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_sys_r <= '0;
      scan_en_r  <= 1'b0;
      fill_r     <= '0;
      scan_idx_r <= '0;
      pend_r     <= 1'b0;
    end else begin
      if (cmd.latch) begin
        scan_idx_r <= '0;
        pend_r     <= 1'b0;
      end else if (cmd.scan_step && !hit) begin
        pend_r <= rd_en;
        if (rd_en) scan_idx_r <= scan_idx_r + 1'b1;
      end
      if (cmd.do_sys) begin
        last_sys_r <= item_ticks_r;
        scan_en_r  <= sys_armed;
      end
      if (cmd.do_miss && (fill_r != FULL_CNT)) fill_r <= fill_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_sys) begin
      res_delta_r   <= sys_delta;
      res_armed_r   <= sys_armed;
      res_id_r      <= '0;
      res_runaway_r <= 1'b0;
      res_strikes_r <= '0;
      res_full_r    <= 1'b0;
    end else if (cmd.do_quiet || cmd.do_hit || cmd.do_miss) begin
      res_delta_r   <= '0;
      res_armed_r   <= scan_en_r;
      res_id_r      <= item_id_r;
      res_runaway_r <= cmd.do_hit && runaway_nxt;
      res_strikes_r <= cmd.do_hit ? strikes_nxt : '0;
      res_full_r    <= cmd.do_miss && (fill_r == FULL_CNT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_system_delta <= res_delta_r;
      out_scan_armed   <= res_armed_r;
      out_reported_id  <= res_id_r;
      out_runaway      <= res_runaway_r;
      out_strike_count <= res_strikes_r;
      out_table_full   <= res_full_r;
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    sts.item_task = item_task_r;
    sts.scan_en   = scan_en_r;
    sts.hit       = hit;
    sts.miss      = miss;
    sts.out_free  = out_free;
  end

endmodule

// ----- src/runaway_task_rate_monitor_top.sv -----
// Top level of the runaway task rate monitor: controller plus datapath.
//
// Usage:
//   Input channel (in_valid / in_stall): one transaction per sample. in_command 0 is a
//   system sample carrying the global busy-tick counter; in_command 1 is a task sample
//   with id, tick counter and may-kill flag. Every transaction gives exactly one result.
//   Output channel (out_valid / out_stall): system difference, scan enable, echoed id,
//   runaway flag, strike count and table-full flag.
//   Config channel (cfg_valid / cfg_ready, always ready): index 0 interval seconds,
//   index 1 trigger level; other indexes are ignored. Write only while idle.
// Flow:
//   A system sample or a task sample while scanning is off passes the decode and emit
//   states into the output register; no new transaction is taken before that is done.
//   A task sample searches the table one entry per cycle through its single read port:
//   a hit updates its slot in place, a new id is inserted after the F stored ids (at
//   most TABLE_ENTRIES) or dropped when the table is full; then the result is emitted.
// Reset (rst_n low, synchronous): config returns to 2 / 20, counters and scan enable
//   clear and the table is emptied through its fill count; no clearing pass is needed.
// Stall: a finished result holds in the output register while out_stall is high; the
//   next transaction is still accepted and worked, then waits until the register frees.
module runaway_task_rate_monitor_top #(
  parameter int unsigned TABLE_ENTRIES = rtrm_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rtrm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rtrm_pkg::CFG_W-1:0]         cfg_data,
  // input transactions
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_command,
  input  logic [rtrm_pkg::ID_W-1:0]          in_task_id,
  input  logic [rtrm_pkg::TICK_W-1:0]        in_tick_counter,
  input  logic                               in_may_kill,
  // result transactions
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [rtrm_pkg::TICK_W-1:0]        out_system_delta,
  output logic                               out_scan_armed,
  output logic [rtrm_pkg::ID_W-1:0]          out_reported_id,
  output logic                               out_runaway,
  output logic [rtrm_pkg::STRIKE_W-1:0]      out_strike_count,
  output logic                               out_table_full
);
  import rtrm_pkg::*;

  rtrm_cmd_t cmd;
  rtrm_sts_t sts;

  // Config registers take a write in any cycle.
  assign cfg_ready = 1'b1;

  rtrm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  rtrm_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_command       (in_command),
    .in_task_id       (in_task_id),
    .in_tick_counter  (in_tick_counter),
    .in_may_kill      (in_may_kill),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_system_delta (out_system_delta),
    .out_scan_armed   (out_scan_armed),
    .out_reported_id  (out_reported_id),
    .out_runaway      (out_runaway),
    .out_strike_count (out_strike_count),
    .out_table_full   (out_table_full)
  );

endmodule
